// ===== rtl/core/vna_pkg.sv =====
// package for the vertex normal accumulator
// item types and command codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package vna_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef struct packed {
    logic        [1:0]  command;
    logic        [9:0]  vertex_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic        [9:0]  corner_a;
    logic        [9:0]  corner_b;
    logic        [9:0]  corner_c;
  } vna_in_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               zero_length;
    logic        [1:0]  answered_command;
  } vna_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/vna_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/vna_norm.sv =====
// iterative vector normalizer: scale search, sum of squares, square root,
// three restoring divisions; no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module vna_norm #(
  parameter int VW = 63,
  parameter int NB = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [VW-1:0] vec_i [3],
  output logic                      done_o,
  output logic                      zero_o,
  output logic signed [NB-1:0]      n_o [3]
);

  localparam int F  = NB - 2;
  localparam int MW = (VW > 31) ? VW : 31;
  localparam int QB = F + 2;
  localparam int NW = 31 + F;
  localparam int DCW = $clog2(QB + 1);
  localparam logic [MW-1:0] HI_LIM = MW'(64'd1 << 30);
  localparam logic [MW-1:0] LO_LIM = MW'(64'd1 << 29);
  localparam logic [QB-1:0] Q_MAX  = QB'(64'd1 << F);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_CHK   = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DINIT = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_DFIN  = 3'd6;

  logic [2:0]          st_q, st_d;
  logic [MW-1:0]       m_q [3];
  logic [MW-1:0]       m_d [3];
  logic [2:0]          neg_q, neg_d;
  logic [1:0]          k_q, k_d;
  logic [59:0]         sq_q, sq_d;
  logic [61:0]         sum_q, sum_d;
  logic [61:0]         s_q, s_d;
  logic [33:0]         rem_q, rem_d;
  logic [30:0]         root_q, root_d;
  logic [4:0]          scnt_q, scnt_d;
  logic [30:0]         drem_q, drem_d;
  logic [QB-1:0]       dnum_q, dnum_d;
  logic [QB-1:0]       quo_q, quo_d;
  logic [DCW-1:0]      dcnt_q, dcnt_d;
  logic signed [NB-1:0] n_q [3];
  logic signed [NB-1:0] n_d [3];
  logic                zero_q, zero_d;
  logic                done_q, done_d;

  logic [MW-1:0]       mx;
  logic signed [MW:0]  vx;
  logic [MW:0]         vmag;
  logic [29:0]         mk;
  logic [33:0]         t_rem, trial;
  logic [NW-1:0]       num;
  logic [31:0]         t_div;
  logic [QB-1:0]       qc;
  logic [NB-1:0]       qn;

  always_comb begin
    st_d = st_q;
    m_d = m_q;
    neg_d = neg_q;
    k_d = k_q;
    sq_d = sq_q;
    sum_d = sum_q;
    s_d = s_q;
    rem_d = rem_q;
    root_d = root_q;
    scnt_d = scnt_q;
    drem_d = drem_q;
    dnum_d = dnum_q;
    quo_d = quo_q;
    dcnt_d = dcnt_q;
    n_d = n_q;
    zero_d = zero_q;
    done_d = 1'b0;
    vx = '0;
    vmag = '0;
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    mk = m_q[k_q][29:0];
    t_rem = {rem_q[31:0], s_q[61:60]};
    trial = {1'b0, root_q, 2'b01};
    num = {1'b0, mk, {F{1'b0}}} + NW'(root_q[30:1]);
    t_div = {drem_q, dnum_q[QB-1]};
    qc = (quo_q > Q_MAX) ? Q_MAX : quo_q;
    qn = NB'(qc);

    case (st_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            vx = (MW+1)'(vec_i[i]);
            vmag = vx[MW] ? 1'b0 - vx : vx;
            m_d[i] = vmag[MW-1:0];
            neg_d[i] = vec_i[i][VW-1];
          end
          st_d = N_CHK;
        end
      end
      N_CHK: begin
        // bring the largest magnitude into [2^29, 2^30), one bit a cycle
        if (mx == '0) begin
          for (int i = 0; i < 3; i++) n_d[i] = '0;
          zero_d = 1'b1;
          done_d = 1'b1;
          st_d = N_IDLE;
        end else if (mx >= HI_LIM) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (mx < LO_LIM) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          k_d = 2'd0;
          sum_d = '0;
          st_d = N_SQ;
        end
      end
      N_SQ: begin
        if (k_q != 2'd3) begin
          sq_d = mk * mk;
        end
        if (k_q != 2'd0) begin
          sum_d = sum_q + {2'b00, sq_q};
        end
        if (k_q == 2'd3) begin
          s_d = sum_q + {2'b00, sq_q};
          rem_d = '0;
          root_d = '0;
          scnt_d = '0;
          st_d = N_SQRT;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      N_SQRT: begin
        // two radicand bits a step
        if (t_rem >= trial) begin
          rem_d = t_rem - trial;
          root_d = {root_q[29:0], 1'b1};
        end else begin
          rem_d = t_rem;
          root_d = {root_q[29:0], 1'b0};
        end
        s_d = s_q << 2;
        scnt_d = scnt_q + 5'd1;
        if (scnt_q == 5'd30) begin
          k_d = 2'd0;
          st_d = N_DINIT;
        end
      end
      N_DINIT: begin
        // quotient is below 2^QB, so the high part starts below the length
        drem_d = 31'(num[NW-1:QB]);
        dnum_d = num[QB-1:0];
        quo_d = '0;
        dcnt_d = '0;
        st_d = N_DIV;
      end
      N_DIV: begin
        if (t_div >= {1'b0, root_q}) begin
          drem_d = 31'(t_div - {1'b0, root_q});
          quo_d = {quo_q[QB-2:0], 1'b1};
        end else begin
          drem_d = t_div[30:0];
          quo_d = {quo_q[QB-2:0], 1'b0};
        end
        dnum_d = dnum_q << 1;
        dcnt_d = dcnt_q + DCW'(1);
        if (dcnt_q == DCW'(QB - 1)) st_d = N_DFIN;
      end
      N_DFIN: begin
        n_d[k_q] = neg_q[k_q] ? $signed(1'b0 - qn) : $signed(qn);
        if (k_q == 2'd2) begin
          zero_d = 1'b0;
          done_d = 1'b1;
          st_d = N_IDLE;
        end else begin
          k_d = k_q + 2'd1;
          st_d = N_DINIT;
        end
      end
      default: st_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= N_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    neg_q <= neg_d;
    k_q <= k_d;
    sq_q <= sq_d;
    sum_q <= sum_d;
    s_q <= s_d;
    rem_q <= rem_d;
    root_q <= root_d;
    scnt_q <= scnt_d;
    drem_q <= drem_d;
    dnum_q <= dnum_d;
    quo_q <= quo_d;
    dcnt_q <= dcnt_d;
    n_q <= n_d;
    zero_q <= zero_d;
  end

  assign done_o = done_q;
  assign zero_o = zero_q;
  assign n_o = n_q;

endmodule

`default_nettype wire

// ===== rtl/core/vertex_normal_accumulator.sv =====
// vertex normal accumulator top level: command sequencer, position and sum rams
// depends on vna_pkg, vna_ram, vna_norm
//
// usage:
//   in channel (in_valid_i / in_stall_o, payload in_data_i) takes one command
//   item; out channel (out_valid_o / out_stall_i, payload out_data_o) returns
//   exactly one result item per command, in order.
//   load writes a vertex position and clears its normal sum. triangle reads
//   three positions, forms the edge cross product from six products on one
//   shared multiplier, normalizes it, then adds the face normal to each corner
//   through a read-modify-write of the sum ram. read normalizes one stored
//   sum. the normalizer does most of the work: a one-bit-a-cycle scale
//   search, a 31-step square root and three divisions of NORMAL_BITS steps.
//   one item is worked on at a time; in_stall_o is high from acceptance until
//   the result moves into the output register. a result waiting under
//   out_stall_i holds still, and the next item may be accepted meanwhile.
//   reset clears control only; ram contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module vertex_normal_accumulator
  import vna_pkg::*;
#(
  parameter int VERTEX_COUNT  = 1024,
  parameter int POSITION_BITS = 24,
  parameter int NORMAL_BITS   = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire vna_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output vna_out_t      out_data_o
);

  localparam int P    = POSITION_BITS;
  localparam int NB   = NORMAL_BITS;
  localparam int AW   = $clog2(VERTEX_COUNT);
  localparam int ACC  = NB + 8;
  localparam int DROP = (P > 30) ? P - 30 : 0;
  localparam int EW   = P + 1 - DROP;
  localparam int CW   = 2 * EW + 1;
  localparam int VW   = (CW > ACC) ? CW : ACC;
  localparam int PW   = 3 * P;
  localparam int SW   = 3 * ACC;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_PRD    = 4'd2;
  localparam logic [3:0] S_EDGE   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_SRD    = 4'd5;
  localparam logic [3:0] S_SCAP   = 4'd6;
  localparam logic [3:0] S_NSTART = 4'd7;
  localparam logic [3:0] S_NWAIT  = 4'd8;
  localparam logic [3:0] S_ACC_RD = 4'd9;
  localparam logic [3:0] S_ACC_WR = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  function automatic logic in_rng(input logic [9:0] x);
    return {7'b0, x} < 17'(VERTEX_COUNT);
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [9:0] x);
    logic [16:0] e;
    e = {7'b0, x};
    return e[AW-1:0];
  endfunction

  logic [3:0]            state_q, state_d;
  logic [2:0]            cnt_q, cnt_d;
  logic [1:0]            cmd_q, cmd_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic [PW-1:0]         lpos_q, lpos_d;
  logic [AW-1:0]         cor_q [3];
  logic [AW-1:0]         cor_d [3];
  logic [PW-1:0]         pv_q [3];
  logic [PW-1:0]         pv_d [3];
  logic signed [EW-1:0]  u_q [3];
  logic signed [EW-1:0]  u_d [3];
  logic signed [EW-1:0]  w_q [3];
  logic signed [EW-1:0]  w_d [3];
  logic signed [2*EW-1:0] prod_q, prod_d;
  logic signed [VW-1:0]  cr_q [3];
  logic signed [VW-1:0]  cr_d [3];
  logic signed [NB-1:0]  n_q [3];
  logic signed [NB-1:0]  n_d [3];
  logic                  zero_q, zero_d;
  logic                  out_valid_q, out_valid_d;
  vna_out_t              out_q, out_d;

  logic                  pos_we, sum_we;
  logic [AW-1:0]         pos_waddr, pos_raddr, sum_waddr, sum_raddr;
  logic [PW-1:0]         pos_wdata, pos_rdata;
  logic [SW-1:0]         sum_wdata, sum_rdata;

  logic                  norm_start, norm_done, norm_zero;
  logic signed [NB-1:0]  norm_n [3];

  logic signed [EW-1:0]  ma, mb;
  logic signed [P:0]     du, dw;
  logic [P:0]            mu, mw;
  logic [P:0]            su, sw;
  logic signed [ACC:0]   sacc;
  logic signed [ACC-1:0] acc_old, acc_new;
  logic signed [VW-1:0]  pext;
  logic [2:0]            pj;
  logic [39:0]           fx, fy, fz;
  logic [P+7:0]          rx, ry, rz;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  vna_ram #(.WIDTH(PW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  vna_ram #(.WIDTH(SW), .DEPTH(VERTEX_COUNT)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  vna_norm #(.VW(VW), .NB(NB)) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (cr_q),
    .done_o  (norm_done),
    .zero_o  (norm_zero),
    .n_o     (norm_n)
  );

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_d = cmd_q;
    idx_d = idx_q;
    lpos_d = lpos_q;
    cor_d = cor_q;
    pv_d = pv_q;
    u_d = u_q;
    w_d = w_q;
    prod_d = prod_q;
    cr_d = cr_q;
    n_d = n_q;
    zero_d = zero_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    pos_we = 1'b0;
    sum_we = 1'b0;
    pos_waddr = idx_q;
    pos_wdata = lpos_q;
    sum_waddr = idx_q;
    sum_wdata = '0;
    pos_raddr = cor_q[0];
    sum_raddr = idx_q;
    norm_start = 1'b0;
    ma = '0;
    mb = '0;
    du = '0;
    dw = '0;
    mu = '0;
    mw = '0;
    su = '0;
    sw = '0;
    pext = VW'(prod_q);
    pj = cnt_q - 3'd1;
    acc_old = '0;
    acc_new = '0;
    sacc = '0;
    rx = {8'b0, in_data_i.pos_x};
    ry = {8'b0, in_data_i.pos_y};
    rz = {8'b0, in_data_i.pos_z};

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_data_i.command;
          idx_d = to_addr(in_data_i.vertex_index);
          lpos_d = {rz[P-1:0], ry[P-1:0], rx[P-1:0]};
          cor_d[0] = to_addr(in_data_i.corner_a);
          cor_d[1] = to_addr(in_data_i.corner_b);
          cor_d[2] = to_addr(in_data_i.corner_c);
          cnt_d = '0;
          for (int i = 0; i < 3; i++) n_d[i] = '0;
          zero_d = 1'b0;
          state_d = S_OUT;
          case (in_data_i.command)
            CMD_LOAD: begin
              if (in_rng(in_data_i.vertex_index)) state_d = S_LOAD;
            end
            CMD_TRI: begin
              if (in_rng(in_data_i.corner_a) && in_rng(in_data_i.corner_b) &&
                  in_rng(in_data_i.corner_c)) begin
                state_d = S_PRD;
              end else begin
                zero_d = 1'b1;
              end
            end
            CMD_READ: begin
              if (in_rng(in_data_i.vertex_index)) state_d = S_SRD;
              else zero_d = 1'b1;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_LOAD: begin
        pos_we = 1'b1;
        sum_we = 1'b1;
        state_d = S_OUT;
      end
      S_PRD: begin
        // reads issued back to back, each read's data lands in the next cycle
        pos_raddr = cor_q[(cnt_q < 3'd3) ? cnt_q[1:0] : 2'd2];
        if (cnt_q != 3'd0) pv_d[pj[1:0]] = pos_rdata;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) state_d = S_EDGE;
      end
      S_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          du = $signed({pv_q[1][i*P+P-1], pv_q[1][i*P +: P]}) -
               $signed({pv_q[0][i*P+P-1], pv_q[0][i*P +: P]});
          dw = $signed({pv_q[2][i*P+P-1], pv_q[2][i*P +: P]}) -
               $signed({pv_q[0][i*P+P-1], pv_q[0][i*P +: P]});
          mu = du[P] ? 1'b0 - du : du;
          mw = dw[P] ? 1'b0 - dw : dw;
          su = mu >> DROP;
          sw = mw >> DROP;
          u_d[i] = du[P] ? $signed(1'b0 - su[EW-1:0]) : $signed(su[EW-1:0]);
          w_d[i] = dw[P] ? $signed(1'b0 - sw[EW-1:0]) : $signed(sw[EW-1:0]);
        end
        cnt_d = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        // one product a cycle, folded into the cross product in the next cycle
        case (cnt_q)
          3'd0: begin ma = u_q[1]; mb = w_q[2]; end
          3'd1: begin ma = u_q[2]; mb = w_q[1]; end
          3'd2: begin ma = u_q[2]; mb = w_q[0]; end
          3'd3: begin ma = u_q[0]; mb = w_q[2]; end
          3'd4: begin ma = u_q[0]; mb = w_q[1]; end
          3'd5: begin ma = u_q[1]; mb = w_q[0]; end
          default: begin ma = '0; mb = '0; end
        endcase
        prod_d = ma * mb;
        if (cnt_q != 3'd0) begin
          if (pj[0]) cr_d[pj[2:1]] = cr_q[pj[2:1]] - pext;
          else cr_d[pj[2:1]] = pext;
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd6) state_d = S_NSTART;
      end
      S_SRD: begin
        sum_raddr = idx_q;
        state_d = S_SCAP;
      end
      S_SCAP: begin
        for (int i = 0; i < 3; i++) begin
          acc_old = $signed(sum_rdata[i*ACC +: ACC]);
          cr_d[i] = VW'(acc_old);
        end
        state_d = S_NSTART;
      end
      S_NSTART: begin
        norm_start = 1'b1;
        state_d = S_NWAIT;
      end
      S_NWAIT: begin
        if (norm_done) begin
          n_d = norm_n;
          zero_d = norm_zero;
          cnt_d = '0;
          state_d = (cmd_q == CMD_TRI) ? S_ACC_RD : S_OUT;
        end
      end
      S_ACC_RD: begin
        sum_raddr = cor_q[cnt_q[1:0]];
        state_d = S_ACC_WR;
      end
      S_ACC_WR: begin
        // the next read issues after this write, so a repeated corner sees it
        sum_we = 1'b1;
        sum_waddr = cor_q[cnt_q[1:0]];
        for (int i = 0; i < 3; i++) begin
          acc_old = $signed(sum_rdata[i*ACC +: ACC]);
          sacc = (ACC+1)'(acc_old) + (ACC+1)'(n_q[i]);
          if (sacc[ACC] != sacc[ACC-1]) acc_new = {sacc[ACC], {(ACC-1){~sacc[ACC]}}};
          else acc_new = sacc[ACC-1:0];
          sum_wdata[i*ACC +: ACC] = acc_new;
        end
        cnt_d = cnt_q + 3'd1;
        state_d = (cnt_q == 3'd2) ? S_OUT : S_ACC_RD;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.normal_x = fx[15:0];
          out_d.normal_y = fy[15:0];
          out_d.normal_z = fz[15:0];
          out_d.zero_length = zero_q;
          out_d.answered_command = cmd_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // fields carry the low 16 bits of each component, zero-extended if NORMAL_BITS is under 16
  assign fx = 40'($unsigned(n_q[0]));
  assign fy = 40'($unsigned(n_q[1]));
  assign fz = 40'($unsigned(n_q[2]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    lpos_q <= lpos_d;
    cor_q <= cor_d;
    pv_q <= pv_d;
    u_q <= u_d;
    w_q <= w_d;
    prod_q <= prod_d;
    cr_q <= cr_d;
    n_q <= n_d;
    zero_q <= zero_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// ===== rtl/core/vna_checker.sv =====
// port-level checks for the vertex normal accumulator, bound to the top level
// depends on vna_pkg
`timescale 1ns / 1ps
`default_nettype none

module vna_checker
  import vna_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire vna_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire vna_out_t out_data_o
);

  // a stalled result item stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed or dropped");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a second item while working");

  // a zero-length result carries a zero normal
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_length |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 &&
      out_data_o.normal_z == '0)
    else $error("zero_length with nonzero normal");

  // a load answers with an all-zero result
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.answered_command == CMD_LOAD |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 &&
      out_data_o.normal_z == '0 && !out_data_o.zero_length)
    else $error("load result not all zero");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

`default_nettype wire
